@@ rtl/core/ppm_sd_pkg.sv @@
`default_nettype none

package ppm_sd_pkg;

  localparam int DIM_BITS_DEF      = 16;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int QUEUE_DEPTH       = 4;
  localparam int SAMPLE_BITS       = 16;
  localparam int LEVEL_BITS        = 17;
  localparam int NUM_CHANNELS      = 3;

  typedef enum logic [2:0] {
    PH_TYPE,
    PH_WIDTH,
    PH_HEIGHT,
    PH_MAXVAL,
    PH_DATA
  } phase_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_HOLD
  } bk_state_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_req_t;

  typedef struct packed {
    logic [15:0]           pixel_row;
    logic [15:0]           pixel_col;
    logic [LEVEL_BITS-1:0] red_level;
    logic [LEVEL_BITS-1:0] green_level;
    logic [LEVEL_BITS-1:0] blue_level;
    logic                  binary_format;
    logic                  last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [15:0]                                 pixel_row;
    logic [15:0]                                 pixel_col;
    logic [NUM_CHANNELS-1:0][SAMPLE_BITS-1:0]    sample;
    logic [SAMPLE_BITS-1:0]                      max_value;
    logic                                        binary_format;
    logic                                        last_pixel;
  } job_t;

endpackage

`default_nettype wire

@@ rtl/core/ppm_sd_front.sv @@
`default_nettype none

module ppm_sd_front #(
  parameter int DIM_BITS = ppm_sd_pkg::DIM_BITS_DEF
) (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic accept_i,
  input  wire ppm_sd_pkg::in_req_t req_i,
  output logic                     job_valid_o,
  output ppm_sd_pkg::job_t         job_o
);

  localparam logic [7:0] ChrZero  = 8'h30;
  localparam logic [7:0] ChrNine  = 8'h39;
  localparam logic [7:0] ChrThree = 8'h33;
  localparam logic [7:0] ChrSix   = 8'h36;
  localparam logic [7:0] ChrHash  = 8'h23;
  localparam logic [7:0] ChrNl    = 8'h0a;
  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [DIM_BITS-1:0] DimMax = '1;

  ppm_sd_pkg::phase_e phase_q, phase_d, cur_phase;
  logic                comment_q, comment_d, cur_comment;
  logic [15:0]         acc_q, acc_d, cur_acc;
  logic                seen_q, seen_d, cur_seen;
  logic [DIM_BITS-1:0] width_q, width_d, cur_width;
  logic [DIM_BITS-1:0] height_q, height_d, cur_height;
  logic [15:0]         maxv_q, maxv_d, cur_maxv;
  logic                bin_q, bin_d, cur_bin;
  logic [1:0]          ch_q, ch_d, cur_ch;
  logic [15:0]         s0_q, s0_d, cur_s0;
  logic [15:0]         s1_q, s1_d, cur_s1;
  logic [DIM_BITS-1:0] row_q, row_d, cur_row;
  logic [DIM_BITS-1:0] col_q, col_d, cur_col;

  logic [7:0]          byte_w;
  logic                sof;
  logic                is_dig;
  logic                is_sep;
  logic [19:0]         acc_mul;
  logic [15:0]         acc_sat;
  logic [DIM_BITS-1:0] acc_clip;
  logic                take;
  logic                emit;
  logic [15:0]         sample;
  logic [DIM_BITS:0]   row_inc;
  logic [DIM_BITS:0]   col_inc;
  logic                last;

  assign byte_w = req_i.data_byte;
  assign sof    = req_i.start_of_file;

  // start of file clears the parse state before the byte is used
  assign cur_phase   = sof ? ppm_sd_pkg::PH_TYPE : phase_q;
  assign cur_comment = sof ? 1'b0 : comment_q;
  assign cur_acc     = sof ? '0 : acc_q;
  assign cur_seen    = sof ? 1'b0 : seen_q;
  assign cur_width   = sof ? '0 : width_q;
  assign cur_height  = sof ? '0 : height_q;
  assign cur_maxv    = sof ? '0 : maxv_q;
  assign cur_bin     = sof ? 1'b0 : bin_q;
  assign cur_ch      = sof ? '0 : ch_q;
  assign cur_s0      = sof ? '0 : s0_q;
  assign cur_s1      = sof ? '0 : s1_q;
  assign cur_row     = sof ? '0 : row_q;
  assign cur_col     = sof ? '0 : col_q;

  assign is_dig   = (byte_w >= ChrZero) && (byte_w <= ChrNine);
  assign is_sep   = (byte_w == ChrSpace) || (byte_w == ChrNl) || (byte_w == ChrHash);
  assign acc_mul  = ({4'b0, cur_acc} << 3) + ({4'b0, cur_acc} << 1) + {16'b0, byte_w[3:0]};
  assign acc_sat  = (|acc_mul[19:16]) ? 16'hffff : acc_mul[15:0];
  assign acc_clip = (32'(cur_acc) > 32'(DimMax)) ? DimMax : cur_acc[DIM_BITS-1:0];

  assign take = accept_i && !cur_comment && (cur_phase == ppm_sd_pkg::PH_DATA) &&
                (cur_bin || (is_sep && cur_seen));
  assign sample  = cur_bin ? {8'b0, byte_w} : cur_acc;
  assign emit    = take && (cur_ch == 2'd2) && (cur_row < cur_height) && (cur_col < cur_width);
  assign row_inc = {1'b0, cur_row} + 1'b1;
  assign col_inc = {1'b0, cur_col} + 1'b1;
  assign last    = (row_inc == {1'b0, cur_height}) && (col_inc == {1'b0, cur_width});

  // next state
  always_comb begin
    phase_d   = phase_q;
    comment_d = comment_q;
    acc_d     = acc_q;
    seen_d    = seen_q;
    width_d   = width_q;
    height_d  = height_q;
    maxv_d    = maxv_q;
    bin_d     = bin_q;
    ch_d      = ch_q;
    s0_d      = s0_q;
    s1_d      = s1_q;
    row_d     = row_q;
    col_d     = col_q;
    if (accept_i) begin
      phase_d   = cur_phase;
      comment_d = cur_comment;
      acc_d     = cur_acc;
      seen_d    = cur_seen;
      width_d   = cur_width;
      height_d  = cur_height;
      maxv_d    = cur_maxv;
      bin_d     = cur_bin;
      ch_d      = cur_ch;
      s0_d      = cur_s0;
      s1_d      = cur_s1;
      row_d     = cur_row;
      col_d     = cur_col;
      priority if (cur_comment) begin
        if (byte_w == ChrNl) begin
          comment_d = 1'b0;
        end
      end else if ((cur_phase == ppm_sd_pkg::PH_DATA) && cur_bin) begin
        // raw sample, handled below
      end else if (cur_phase == ppm_sd_pkg::PH_TYPE) begin
        priority if (byte_w == ChrHash) begin
          comment_d = 1'b1;
        end else if (byte_w == ChrThree) begin
          bin_d   = 1'b0;
          phase_d = ppm_sd_pkg::PH_WIDTH;
        end else if (byte_w == ChrSix) begin
          bin_d   = 1'b1;
          phase_d = ppm_sd_pkg::PH_WIDTH;
        end else begin
          // other type bytes are skipped
        end
        acc_d  = '0;
        seen_d = 1'b0;
      end else if (is_dig) begin
        acc_d  = acc_sat;
        seen_d = 1'b1;
      end else if (is_sep) begin
        if (byte_w == ChrHash) begin
          comment_d = 1'b1;
        end
        if (cur_seen) begin
          acc_d  = '0;
          seen_d = 1'b0;
          unique case (cur_phase)
            ppm_sd_pkg::PH_WIDTH: begin
              width_d = acc_clip;
              phase_d = ppm_sd_pkg::PH_HEIGHT;
            end
            ppm_sd_pkg::PH_HEIGHT: begin
              height_d = acc_clip;
              phase_d  = ppm_sd_pkg::PH_MAXVAL;
            end
            ppm_sd_pkg::PH_MAXVAL: begin
              maxv_d  = cur_acc;
              phase_d = ppm_sd_pkg::PH_DATA;
              ch_d    = '0;
            end
            default: begin
            end
          endcase
        end
      end else begin
        // stray bytes inside numbers are ignored
      end
      if (take) begin
        unique case (cur_ch)
          2'd0: begin
            s0_d = sample;
            ch_d = 2'd1;
          end
          2'd1: begin
            s1_d = sample;
            ch_d = 2'd2;
          end
          default: begin
            ch_d = 2'd0;
            if (emit) begin
              if (col_inc >= {1'b0, cur_width}) begin
                col_d = '0;
                row_d = row_inc[DIM_BITS-1:0];
              end else begin
                col_d = col_inc[DIM_BITS-1:0];
              end
            end
          end
        endcase
      end
    end
  end

  // outputs
  always_comb begin
    job_valid_o             = emit;
    job_o.pixel_row         = 16'(cur_row);
    job_o.pixel_col         = 16'(cur_col);
    job_o.sample[0]         = cur_s0;
    job_o.sample[1]         = cur_s1;
    job_o.sample[2]         = sample;
    job_o.max_value         = cur_maxv;
    job_o.binary_format     = cur_bin;
    job_o.last_pixel        = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ppm_sd_pkg::PH_TYPE;
      comment_q <= 1'b0;
      acc_q     <= '0;
      seen_q    <= 1'b0;
      width_q   <= '0;
      height_q  <= '0;
      maxv_q    <= '0;
      bin_q     <= 1'b0;
      ch_q      <= '0;
      s0_q      <= '0;
      s1_q      <= '0;
      row_q     <= '0;
      col_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      comment_q <= comment_d;
      acc_q     <= acc_d;
      seen_q    <= seen_d;
      width_q   <= width_d;
      height_q  <= height_d;
      maxv_q    <= maxv_d;
      bin_q     <= bin_d;
      ch_q      <= ch_d;
      s0_q      <= s0_d;
      s1_q      <= s1_d;
      row_q     <= row_d;
      col_q     <= col_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ppm_sd_fifo.sv @@
`default_nettype none

module ppm_sd_fifo #(
  parameter int DEPTH = ppm_sd_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire ppm_sd_pkg::job_t data_i,
  input  wire logic             pop_i,
  output ppm_sd_pkg::job_t      data_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntBits = $clog2(DEPTH + 1);
  localparam logic [PtrBits-1:0] PtrLast = PtrBits'(DEPTH - 1);
  localparam logic [CntBits-1:0] CntFull = CntBits'(DEPTH);

  ppm_sd_pkg::job_t   mem_q [DEPTH];
  logic [PtrBits-1:0] wr_q, wr_d;
  logic [PtrBits-1:0] rd_q, rd_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrLast) ? '0 : PtrBits'(wr_q + 1'b1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrLast) ? '0 : PtrBits'(rd_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = CntBits'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = CntBits'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ppm_sd_back.sv @@
`default_nettype none

module ppm_sd_back #(
  parameter int FRACTION_BITS = ppm_sd_pkg::FRACTION_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             empty_i,
  input  wire ppm_sd_pkg::job_t job_i,
  output logic                  pop_o,
  output logic                  empty_o,
  input  wire logic             pop_i,
  output ppm_sd_pkg::pixel_t    rsp_o
);

  localparam int CntBits   = $clog2(FRACTION_BITS);
  localparam int LevelBits = FRACTION_BITS + 1;
  localparam int NumCh     = ppm_sd_pkg::NUM_CHANNELS;
  localparam int SBits     = ppm_sd_pkg::SAMPLE_BITS;
  localparam logic [CntBits-1:0]   LastCnt   = CntBits'(FRACTION_BITS - 1);
  localparam logic [LevelBits-1:0] FullScale = LevelBits'(1) << FRACTION_BITS;

  ppm_sd_pkg::bk_state_e state_q, state_d;
  logic                      out_valid_q, out_valid_d;
  logic [CntBits-1:0]        cnt_q;
  logic [SBits-1:0]          div_q;
  logic [SBits-1:0]          rem_q  [NumCh];
  logic [FRACTION_BITS-1:0]  quot_q [NumCh];
  logic [NumCh-1:0]          sat_q;
  logic [15:0]               row_q;
  logic [15:0]               col_q;
  logic                      bin_q;
  logic                      last_q;
  ppm_sd_pkg::pixel_t        out_q;

  logic [SBits-1:0]          div_load;
  logic [SBits:0]            rem2   [NumCh];
  logic [NumCh-1:0]          ge;
  logic [SBits-1:0]          rem_nx [NumCh];
  logic [LevelBits-1:0]      level  [NumCh];
  logic                      out_free;
  logic                      load_out;

  assign out_free = !out_valid_q || pop_i;
  assign div_load = (job_i.max_value == '0) ? SBits'(1) : job_i.max_value;

  // one quotient bit per lane and cycle
  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      rem2[i]   = {rem_q[i], 1'b0};
      ge[i]     = (rem2[i] >= {1'b0, div_q});
      rem_nx[i] = ge[i] ? SBits'(rem2[i] - {1'b0, div_q}) : rem2[i][SBits-1:0];
      level[i]  = sat_q[i] ? FullScale : {1'b0, quot_q[i]};
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ppm_sd_pkg::BK_IDLE: begin
        if (!empty_i) begin
          state_d = ppm_sd_pkg::BK_RUN;
        end
      end
      ppm_sd_pkg::BK_RUN: begin
        if (cnt_q == LastCnt) begin
          state_d = ppm_sd_pkg::BK_HOLD;
        end
      end
      ppm_sd_pkg::BK_HOLD: begin
        if (out_free) begin
          state_d = ppm_sd_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = ppm_sd_pkg::BK_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    pop_o       = (state_q == ppm_sd_pkg::BK_IDLE) && !empty_i;
    load_out    = (state_q == ppm_sd_pkg::BK_HOLD) && out_free;
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign empty_o = !out_valid_q;
  assign rsp_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ppm_sd_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        cnt_q <= '0;
      end else if (state_q == ppm_sd_pkg::BK_RUN) begin
        cnt_q <= CntBits'(cnt_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      div_q  <= div_load;
      row_q  <= job_i.pixel_row;
      col_q  <= job_i.pixel_col;
      bin_q  <= job_i.binary_format;
      last_q <= job_i.last_pixel;
      for (int i = 0; i < NumCh; i++) begin
        sat_q[i]  <= (job_i.sample[i] >= div_load);
        rem_q[i]  <= (job_i.sample[i] >= div_load) ? '0 : job_i.sample[i];
        quot_q[i] <= '0;
      end
    end else if (state_q == ppm_sd_pkg::BK_RUN) begin
      for (int i = 0; i < NumCh; i++) begin
        rem_q[i]  <= rem_nx[i];
        quot_q[i] <= {quot_q[i][FRACTION_BITS-2:0], ge[i]};
      end
    end
    if (load_out) begin
      out_q.pixel_row     <= row_q;
      out_q.pixel_col     <= col_q;
      out_q.red_level     <= ppm_sd_pkg::LEVEL_BITS'(level[0]);
      out_q.green_level   <= ppm_sd_pkg::LEVEL_BITS'(level[1]);
      out_q.blue_level    <= ppm_sd_pkg::LEVEL_BITS'(level[2]);
      out_q.binary_format <= bin_q;
      out_q.last_pixel    <= last_q;
    end
  end

`ifndef SYNTHESIS
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ppm_sd_pkg::BK_RUN) |->
      (rem_q[0] < div_q) && (rem_q[1] < div_q) && (rem_q[2] < div_q))
    else $error("divider remainder not below divisor");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ppm_sd_pkg::BK_RUN) |-> (div_q != '0))
    else $error("zero divisor in divider");

  a_result_after_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ppm_sd_pkg::BK_HOLD))
    else $error("result appeared without finished division");
`endif

endmodule

`default_nettype wire

@@ rtl/core/ppm_stream_decoder_unit.sv @@
// PPM (P3/P6) byte-stream decoder. A byte is taken in every cycle in which
// push_i is high and full_o is low; the parser handles header and samples at
// one byte per cycle and places each finished pixel into a short pixel queue.
// full_o is high whenever that queue is full, for header bytes too. Each
// pixel then goes to the back end, where three restoring-divider lanes
// scale red, green and blue by maxval in lockstep, one quotient bit per
// cycle. The back end takes a new pixel from the queue only after the last
// one's result has entered the output register. Header and comment bytes
// go at one per cycle while full_o is low. Results leave through an
// output register and are read with empty_o and pop_i.
`default_nettype none

module ppm_stream_decoder_unit #(
  parameter int DIM_BITS      = ppm_sd_pkg::DIM_BITS_DEF,
  parameter int FRACTION_BITS = ppm_sd_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  output logic                     full_o,
  input  wire ppm_sd_pkg::in_req_t req_i,
  output logic                     empty_o,
  input  wire logic                pop_i,
  output ppm_sd_pkg::pixel_t       rsp_o
);

  logic             accept;
  logic             job_valid;
  ppm_sd_pkg::job_t job;
  ppm_sd_pkg::job_t q_job;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;

  assign full_o = q_full;
  assign accept = push_i && !q_full;

  ppm_sd_front #(
    .DIM_BITS (DIM_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_i       (req_i),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  ppm_sd_fifo #(
    .DEPTH (ppm_sd_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .data_i  (job),
    .pop_i   (q_pop),
    .data_o  (q_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ppm_sd_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .job_i   (q_job),
    .pop_o   (q_pop),
    .empty_o (empty_o),
    .pop_i   (pop_i),
    .rsp_o   (rsp_o)
  );

endmodule

`default_nettype wire
